>>> hw/rtl/clar_pkg.sv
// ----------------------------------------------------------------------------
// clar_pkg
// shared types and codes for the compacting list core
// ----------------------------------------------------------------------------
package clar_pkg;

  localparam logic [1:0] ST_APPENDED  = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_REMOVED   = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  localparam logic MODE_APPEND = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN
  } state_t;

  typedef struct packed {
    logic act;
    logic found;
  } wave_t;

endpackage

>>> hw/rtl/clar_cell.sv
// ----------------------------------------------------------------------------
// clar_cell
// one list slot: holds an entry, takes an appended value when it is the next
// free slot, matches the passing search wave against the key and pulls the
// upper neighbor's entry down once the match lies at or below this slot
module clar_cell #(
  parameter int IDX   = 0,
  parameter int CW    = 7,
  parameter int PW    = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [CW-1:0]        held_i,
  input  logic signed [31:0]   key_i,
  input  logic                 app_i,
  input  logic signed [31:0]   din_i,
  input  logic signed [31:0]   nxt_val_i,
  input  clar_pkg::wave_t      wave_i,
  input  logic [PW-1:0]        pos_i,
  output clar_pkg::wave_t      wave_o,
  output logic [PW-1:0]        pos_o,
  output logic signed [31:0]   val_o
);

  localparam logic [CW-1:0] MY_IDX = CW'(IDX);
  localparam logic [PW-1:0] MY_POS = PW'(IDX);

  logic signed [31:0] val_r, val_nxt;
  clar_pkg::wave_t    wave_r, wave_nxt;
  logic [PW-1:0]      pos_r, pos_nxt;
  logic               live;
  logic               hit;

  assign live = held_i > MY_IDX;
  assign hit  = wave_i.act & ~wave_i.found & live & (val_r == key_i);

  always_comb begin
    val_nxt = val_r;
    if (app_i && (held_i == MY_IDX)) begin
      val_nxt = din_i;
    end else if (wave_i.act && (wave_i.found || hit)) begin
      val_nxt = nxt_val_i;
    end
    wave_nxt.act   = wave_i.act;
    wave_nxt.found = wave_i.found | hit;
    pos_nxt        = hit ? MY_POS : pos_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wave_r <= '0;
    end else begin
      wave_r <= wave_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    pos_r <= pos_nxt;
  end

  assign wave_o = wave_r;
  assign pos_o  = pos_r;
  assign val_o  = val_r;

endmodule

>>> hw/rtl/compacting_list_append_remove_core.sv
// ----------------------------------------------------------------------------
// compacting_list_append_remove_core
// ordered list of signed 32-bit entries with append and remove-by-value
// ----------------------------------------------------------------------------
// An append is done in the cycle it is accepted, so appends can be taken one
// per cycle while the result register drains. A remove sends a search wave
// through the row of DEPTH cells, one cell per cycle; the first matching cell
// and every cell above it pull the next entry down as the wave passes, so the
// list compacts on the fly. A remove holds the input off from its acceptance
// until its result is loaded, while the wave walks through the cell row and
// while the result side stalls. An append to a full list reports full with
// position zero; a remove with no match reports not found with position zero.
// No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module compacting_list_append_remove_core #(
  parameter int DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_mode,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_status,
  output logic [5:0]         out_position,
  output logic [6:0]         out_count
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = $clog2(DEPTH);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  clar_pkg::state_t   state_r, state_nxt;
  logic [CW-1:0]      held_r, held_nxt;
  logic signed [31:0] key_r, key_nxt;
  logic               start_r, start_nxt;
  logic               res_found_r, res_found_nxt;
  logic [PW-1:0]      res_pos_r, res_pos_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [5:0]         out_position_r, out_position_nxt;
  logic [6:0]         out_count_r, out_count_nxt;

  logic               accept;
  logic               out_free;
  logic               app;

  logic signed [31:0] val_w  [DEPTH];
  clar_pkg::wave_t    wave_w [DEPTH];
  logic [PW-1:0]      pos_w  [DEPTH];
  clar_pkg::wave_t    wave_in;

  logic [PW+5:0]      pos_ext;
  logic [CW+6:0]      cnt_ext;

  assign out_free = ~out_valid_r | ~out_stall;
  assign in_stall = ~((state_r == clar_pkg::S_IDLE) & out_free);
  assign accept   = in_valid & ~in_stall;
  assign app      = accept & (in_mode == clar_pkg::MODE_APPEND) & (held_r != FULL_CNT);

  assign wave_in.act   = start_r;
  assign wave_in.found = 1'b0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [31:0] nxt_val;
    clar_pkg::wave_t    wave_prev;
    logic [PW-1:0]      pos_prev;

    if (g == DEPTH - 1) begin : g_top
      assign nxt_val = val_w[g];
    end else begin : g_mid
      assign nxt_val = val_w[g+1];
    end

    if (g == 0) begin : g_first
      assign wave_prev = wave_in;
      assign pos_prev  = '0;
    end else begin : g_rest
      assign wave_prev = wave_w[g-1];
      assign pos_prev  = pos_w[g-1];
    end

    clar_cell #(
      .IDX  (g),
      .CW   (CW),
      .PW   (PW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .held_i   (held_r),
      .key_i    (key_r),
      .app_i    (app),
      .din_i    (in_value),
      .nxt_val_i(nxt_val),
      .wave_i   (wave_prev),
      .pos_i    (pos_prev),
      .wave_o   (wave_w[g]),
      .pos_o    (pos_w[g]),
      .val_o    (val_w[g])
    );
  end

  always_comb begin
    state_nxt        = state_r;
    held_nxt         = held_r;
    key_nxt          = key_r;
    start_nxt        = 1'b0;
    res_found_nxt    = res_found_r;
    res_pos_nxt      = res_pos_r;
    out_valid_nxt    = out_valid_r & out_stall;
    out_status_nxt   = out_status_r;
    out_position_nxt = out_position_r;
    out_count_nxt    = out_count_r;
    pos_ext          = '0;
    cnt_ext          = '0;
    case (state_r)
      clar_pkg::S_IDLE: begin
        if (accept) begin
          if (in_mode == clar_pkg::MODE_REMOVE) begin
            key_nxt   = in_value;
            start_nxt = 1'b1;
            state_nxt = clar_pkg::S_SCAN;
          end else if (held_r == FULL_CNT) begin
            cnt_ext          = (CW+7)'(held_r);
            out_valid_nxt    = 1'b1;
            out_status_nxt   = clar_pkg::ST_FULL;
            out_position_nxt = '0;
            out_count_nxt    = cnt_ext[6:0];
          end else begin
            held_nxt         = held_r + 1'b1;
            pos_ext          = (PW+6)'(held_r);
            cnt_ext          = (CW+7)'(held_nxt);
            out_valid_nxt    = 1'b1;
            out_status_nxt   = clar_pkg::ST_APPENDED;
            out_position_nxt = pos_ext[5:0];
            out_count_nxt    = cnt_ext[6:0];
          end
        end
      end
      clar_pkg::S_SCAN: begin
        if (wave_w[DEPTH-1].act) begin
          res_found_nxt = wave_w[DEPTH-1].found;
          res_pos_nxt   = pos_w[DEPTH-1];
          state_nxt     = clar_pkg::S_DRAIN;
        end
      end
      clar_pkg::S_DRAIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (res_found_r) begin
            held_nxt         = held_r - 1'b1;
            pos_ext          = (PW+6)'(res_pos_r);
            out_status_nxt   = clar_pkg::ST_REMOVED;
            out_position_nxt = pos_ext[5:0];
          end else begin
            out_status_nxt   = clar_pkg::ST_NOT_FOUND;
            out_position_nxt = '0;
          end
          cnt_ext       = (CW+7)'(held_nxt);
          out_count_nxt = cnt_ext[6:0];
          state_nxt     = clar_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = clar_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clar_pkg::S_IDLE;
      held_r      <= '0;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r          <= key_nxt;
    res_found_r    <= res_found_nxt;
    res_pos_r      <= res_pos_nxt;
    out_status_r   <= out_status_nxt;
    out_position_r <= out_position_nxt;
    out_count_r    <= out_count_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_position = out_position_r;
  assign out_count    = out_count_r;

endmodule

>>> hw/rtl/clar_checker.sv
// ----------------------------------------------------------------------------
// clar_checker
// port-level checks for the compacting list core
// ----------------------------------------------------------------------------
module clar_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               in_mode,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         out_status,
  input logic [5:0]         out_position,
  input logic [6:0]         out_count
);

  logic in_xact;
  assign in_xact = in_valid & ~in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status)
      && $stable(out_position) && $stable(out_count))
    else $error("stalled result changed");

  a_zero_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == clar_pkg::ST_FULL || out_status == clar_pkg::ST_NOT_FOUND)
      |-> out_position == 6'd0)
    else $error("full or not found with nonzero position");

  a_append_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_xact && (in_mode == clar_pkg::MODE_APPEND) |=> out_valid
      && (out_status == clar_pkg::ST_APPENDED || out_status == clar_pkg::ST_FULL))
    else $error("append transaction without result in next cycle");

  a_remove_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_xact && (in_mode == clar_pkg::MODE_REMOVE) |=> in_stall)
    else $error("input taken while remove in progress");

endmodule

bind compacting_list_append_remove_core clar_checker u_clar_checker (.*);
